FILE: hdl/dmxfr_pkg.sv
// Package for the DMX serial frame receiver: constants, state codes and the result type.
// Used by the interfaces, the memory, the controller and the top level.
// It has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package dmxfr_pkg;

  // Default sizes of the two memories
  localparam int unsigned NUM_CHANNELS_DEF = 512;
  localparam int unsigned MAX_PAYLOAD_DEF  = 514;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CH_W    = 9;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Frame delimiters and layout
  localparam logic [BYTE_W-1:0] START_BYTE  = 8'h7E;
  localparam logic [BYTE_W-1:0] END_BYTE    = 8'hE7;
  localparam logic [BYTE_W-1:0] LABEL_RESET = 8'd5;
  localparam logic [LEN_W-1:0]  FIRST_DATA  = 10'd2;

  // Request function codes
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_LABEL = 1'b0;

  // Frame parser phase
  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_LABEL   = 6'b000010,
    PH_LEN_LO  = 6'b000100,
    PH_LEN_HI  = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_END     = 6'b100000
  } phase_e;

  // Request sequencer state
  typedef enum logic [4:0] {
    SQ_CLEAR  = 5'b00001,
    SQ_IDLE   = 5'b00010,
    SQ_READ   = 5'b00100,
    SQ_COMMIT = 5'b01000,
    SQ_DONE   = 5'b10000
  } seq_e;

  // One result
  typedef struct packed {
    logic [BYTE_W-1:0] read_value;
    logic              frame_done;
    logic              frame_dropped;
    logic [LEN_W-1:0]  channels_written;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/dmxfr_if.sv
// Valid/ready channel interfaces for requests into and results out of the receiver.
// Depends on dmxfr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

// Request channel: a received byte or a channel read
interface dmxfr_req_if
  import dmxfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              func;
  logic [BYTE_W-1:0] rx_byte;
  logic [CH_W-1:0]   channel;

  modport source (output valid, func, rx_byte, channel, input ready);
  modport sink   (input valid, func, rx_byte, channel, output ready);
endinterface

// Result channel: one result per request
interface dmxfr_res_if
  import dmxfr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_value;
  logic              frame_done;
  logic              frame_dropped;
  logic [LEN_W-1:0]  channels_written;

  modport source (output valid, read_value, frame_done, frame_dropped, channels_written,
                  input ready);
  modport sink   (input valid, read_value, frame_done, frame_dropped, channels_written,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/dmxfr_ram.sv
// Byte-wide simple dual-port RAM with one write port and one registered read port.
// Used for the staging buffer and the channel store; depends on dmxfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmxfr_ram
  import dmxfr_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_PAYLOAD_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [BYTE_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dmxfr_ctrl.sv
// Frame parser and request sequencer: drives both memories and the result register.
// Depends on dmxfr_pkg and the channel interfaces in dmxfr_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module dmxfr_ctrl
  import dmxfr_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int unsigned MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
  localparam int unsigned CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int unsigned ST_AW = $clog2(MAX_PAYLOAD)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  dmxfr_req_if.sink              req_i,
  dmxfr_res_if.source            res_o,
  input  wire logic [BYTE_W-1:0] label_i,
  // Staging buffer
  output logic                   st_we_o,
  output logic      [ST_AW-1:0]  st_waddr_o,
  output logic      [BYTE_W-1:0] st_wdata_o,
  output logic                   st_re_o,
  output logic      [ST_AW-1:0]  st_raddr_o,
  input  wire logic [BYTE_W-1:0] st_rdata_i,
  // Channel store
  output logic                   ch_we_o,
  output logic      [CH_AW-1:0]  ch_waddr_o,
  output logic      [BYTE_W-1:0] ch_wdata_o,
  output logic                   ch_re_o,
  output logic      [CH_AW-1:0]  ch_raddr_o,
  input  wire logic [BYTE_W-1:0] ch_rdata_i
);

  seq_e              seq_q, seq_d;
  phase_e            phase_q, phase_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  bc_q, bc_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  n_q, n_d;
  logic              pend_q, pend_d;
  logic [CH_AW-1:0]  pend_addr_q, pend_addr_d;
  logic              ch_ok_q, ch_ok_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;

  logic              acc;
  logic              out_free;
  result_t           byte_res;
  logic [15:0]       len16;
  logic [LEN_W-1:0]  bc_inc;
  logic [LEN_W-1:0]  body_len;
  logic [LEN_W-1:0]  commit_n;

  assign req_i.ready = (seq_q == SQ_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;

  // Result register toward the sink
  assign res_o.valid            = out_valid_q;
  assign res_o.read_value       = out_q.read_value;
  assign res_o.frame_done       = out_q.frame_done;
  assign res_o.frame_dropped    = out_q.frame_dropped;
  assign res_o.channels_written = out_q.channels_written;

  // Length arithmetic for the parser and the commit
  assign len16    = {req_i.rx_byte, len_q[BYTE_W-1:0]};
  assign bc_inc   = bc_q + 1'b1;
  assign body_len = (len_q > FIRST_DATA) ? (len_q - FIRST_DATA) : '0;
  assign commit_n = (body_len > LEN_W'(NUM_CHANNELS)) ? LEN_W'(NUM_CHANNELS) : body_len;

  // Frame parser: advances on every accepted received byte
  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    bc_d       = bc_q;
    byte_res   = '0;
    st_we_o    = 1'b0;
    st_waddr_o = bc_q[ST_AW-1:0];
    st_wdata_o = req_i.rx_byte;
    if (acc && (req_i.func == FUNC_BYTE)) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (req_i.rx_byte == START_BYTE) begin
            phase_d = PH_LABEL;
          end
        end
        PH_LABEL: begin
          // A repeated start byte keeps waiting for the label
          if (req_i.rx_byte == label_i) begin
            phase_d = PH_LEN_LO;
          end else if (req_i.rx_byte != START_BYTE) begin
            phase_d = PH_HUNT;
          end
        end
        PH_LEN_LO: begin
          len_d   = {{(LEN_W-BYTE_W){1'b0}}, req_i.rx_byte};
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (len16 > 16'(MAX_PAYLOAD)) begin
            byte_res.frame_dropped = 1'b1;
            len_d   = '0;
            phase_d = PH_HUNT;
          end else begin
            len_d   = len16[LEN_W-1:0];
            bc_d    = '0;
            phase_d = (len16 == 16'd0) ? PH_END : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          st_we_o = (bc_q < LEN_W'(MAX_PAYLOAD));
          bc_d    = bc_inc;
          if (bc_inc >= len_q) begin
            phase_d = PH_END;
          end
        end
        PH_END: begin
          if (req_i.rx_byte == END_BYTE) begin
            byte_res.frame_done       = 1'b1;
            byte_res.channels_written = commit_n;
          end else begin
            byte_res.frame_dropped = 1'b1;
          end
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  // Request sequencer: store clear, channel reads, frame commit and result hand-off
  always_comb begin
    seq_d       = seq_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    ch_ok_d     = ch_ok_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_d       = out_q;
    ch_we_o     = 1'b0;
    ch_waddr_o  = pend_addr_q;
    ch_wdata_o  = st_rdata_i;
    ch_re_o     = 1'b0;
    ch_raddr_o  = req_i.channel[CH_AW-1:0];
    st_re_o     = 1'b0;
    st_raddr_o  = ST_AW'(cnt_q + FIRST_DATA);
    unique case (seq_q)
      SQ_CLEAR: begin
        // Zero one store entry per cycle after reset
        ch_we_o    = 1'b1;
        ch_waddr_o = cnt_q[CH_AW-1:0];
        ch_wdata_o = '0;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LEN_W'(NUM_CHANNELS - 1)) begin
          cnt_d = '0;
          seq_d = SQ_IDLE;
        end
      end
      SQ_IDLE: begin
        if (acc) begin
          if (req_i.func == FUNC_READ) begin
            ch_re_o = 1'b1;
            ch_ok_d = ({1'b0, req_i.channel} < LEN_W'(NUM_CHANNELS));
            seq_d   = SQ_READ;
          end else begin
            res_d = byte_res;
            if (byte_res.channels_written != '0) begin
              cnt_d = '0;
              n_d   = commit_n;
              seq_d = SQ_COMMIT;
            end else begin
              seq_d = SQ_DONE;
            end
          end
        end
      end
      SQ_READ: begin
        res_d            = '0;
        res_d.read_value = ch_ok_q ? ch_rdata_i : '0;
        seq_d            = SQ_DONE;
      end
      SQ_COMMIT: begin
        // Read staged byte k+2, write it to channel k in the next cycle
        ch_we_o = pend_q;
        if (cnt_q != n_q) begin
          st_re_o     = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = cnt_q[CH_AW-1:0];
          cnt_d       = cnt_q + 1'b1;
        end else begin
          seq_d = SQ_DONE;
        end
      end
      SQ_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          seq_d       = SQ_IDLE;
        end
      end
      default: begin
        seq_d = SQ_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SQ_CLEAR;
      phase_q     <= PH_HUNT;
      len_q       <= '0;
      bc_q        <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      ch_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      phase_q     <= phase_d;
      len_q       <= len_d;
      bc_q        <= bc_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      pend_q      <= pend_d;
      ch_ok_q     <= ch_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

endmodule

`default_nettype wire

FILE: hdl/dmx_serial_frame_receiver_top.sv
// DMX serial frame receiver, top level: APB label register, staging buffer, channel store.
// Flow: a received byte goes through the done state to the result register, a channel read
// through the read state first, a good end byte committing n channels (n up to NUM_CHANNELS)
// through the commit loop. One request at a time: the next is accepted once the last result
// is in the result register; a stalled result side delays that. Copying sets the worst case.
// Reset: the store is zeroed entry by entry with ready low; APB works.
`timescale 1ns / 1ps
`default_nettype none

module dmx_serial_frame_receiver_top
  import dmxfr_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int unsigned MAX_PAYLOAD  = MAX_PAYLOAD_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  dmxfr_req_if.sink               req_i,
  dmxfr_res_if.source             res_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int unsigned CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned ST_AW = $clog2(MAX_PAYLOAD);

  logic [BYTE_W-1:0] label_q, label_d;
  logic              cfg_wr;

  logic              st_we, st_re;
  logic [ST_AW-1:0]  st_waddr, st_raddr;
  logic [BYTE_W-1:0] st_wdata, st_rdata;
  logic              ch_we, ch_re;
  logic [CH_AW-1:0]  ch_waddr, ch_raddr;
  logic [BYTE_W-1:0] ch_wdata, ch_rdata;

  // APB label register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LABEL);
  assign label_d = cfg_wr ? pwdata[BYTE_W-1:0] : label_q;
  assign prdata = (paddr[2] == REG_LABEL) ? {{(PDATA_W-BYTE_W){1'b0}}, label_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_q <= LABEL_RESET;
    end else begin
      label_q <= label_d;
    end
  end

  // Staging buffer for the payload of the frame in flight
  dmxfr_ram #(
    .DEPTH (MAX_PAYLOAD)
  ) u_stage (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // Channel store
  dmxfr_ram #(
    .DEPTH (NUM_CHANNELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_waddr),
    .wdata_i (ch_wdata),
    .re_i    (ch_re),
    .raddr_i (ch_raddr),
    .rdata_o (ch_rdata)
  );

  // Parser and sequencer
  dmxfr_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_PAYLOAD  (MAX_PAYLOAD)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .res_o      (res_o),
    .label_i    (label_q),
    .st_we_o    (st_we),
    .st_waddr_o (st_waddr),
    .st_wdata_o (st_wdata),
    .st_re_o    (st_re),
    .st_raddr_o (st_raddr),
    .st_rdata_i (st_rdata),
    .ch_we_o    (ch_we),
    .ch_waddr_o (ch_waddr),
    .ch_wdata_o (ch_wdata),
    .ch_re_o    (ch_re),
    .ch_raddr_o (ch_raddr),
    .ch_rdata_i (ch_rdata)
  );

`ifndef SYNTHESIS
  // A request is worked on alone, so ready drops right after an acceptance.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another was in work");

  // A frame ends either committed or dropped, never both.
  a_done_xor_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.frame_done && res_o.frame_dropped))
    else $error("frame both committed and dropped");

  // Committed channels are only reported by a good frame end.
  a_count_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.channels_written != '0)) |-> res_o.frame_done)
    else $error("channel count without a committed frame");

  // The staging buffer is filled and copied out in different phases.
  a_stage_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_we && st_re))
    else $error("staging buffer written during commit");
`endif

endmodule

`default_nettype wire

FILE: bench/dmx_serial_frame_receiver_top_tb.sv
// Self-checking testbench for the DMX serial frame receiver top level.
// It depends on dmxfr_pkg, the request/result interfaces and dmx_serial_frame_receiver_top.
// A frame tracker predicts every result and checks the results in order.
`timescale 1ns / 1ps

module dmx_serial_frame_receiver_top_tb;
  import dmxfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned IDLE_PCT    = 7;
  localparam int unsigned DRAIN_WAIT  = 600;
  localparam logic [PADDR_W-1:0] LABEL_ADDR  = 3'd0;
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = 3'd4;

  // Tracks the parser, the staging bytes and the channel store, and holds the
  // results still owed by the block.
  class dmx_frame_tracker;
    logic [BYTE_W-1:0] label;
    phase_e            phase;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  count;
    logic [BYTE_W-1:0] staging [MAX_PAYLOAD_DEF];
    logic [BYTE_W-1:0] levels [NUM_CHANNELS_DEF];
    result_t           owed_results [$];
    int unsigned       mismatches;

    function new();
      label = LABEL_RESET;
      phase = PH_HUNT;
      length = '0;
      count = '0;
      foreach (levels[i]) levels[i] = '0;
      mismatches = 0;
    endfunction

    function void write_register(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
      if (addr[2] == REG_LABEL) label = data[BYTE_W-1:0];
    endfunction

    // Advance the tracked state by one accepted request and note its result.
    function void accept_request(logic fn, logic [BYTE_W-1:0] b, logic [CH_W-1:0] ch);
      result_t     r;
      int unsigned full_len;
      int unsigned k;
      r = '0;
      if (fn == FUNC_READ) begin
        if (ch < NUM_CHANNELS_DEF) r.read_value = levels[ch];
      end else begin
        case (phase)
          PH_HUNT: begin
            if (b == START_BYTE) phase = PH_LABEL;
          end
          PH_LABEL: begin
            if (b == label) phase = PH_LEN_LO;
            else if (b != START_BYTE) phase = PH_HUNT;
          end
          PH_LEN_LO: begin
            length = {2'b00, b};
            phase = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            full_len = {b, length[BYTE_W-1:0]};
            if (full_len > MAX_PAYLOAD_DEF) begin
              r.frame_dropped = 1'b1;
              length = '0;
              phase = PH_HUNT;
            end else begin
              length = full_len[LEN_W-1:0];
              count = '0;
              phase = (full_len == 0) ? PH_END : PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (count < MAX_PAYLOAD_DEF) staging[count] = b;
            count = count + 1'b1;
            if (count >= length) phase = PH_END;
          end
          PH_END: begin
            if (b == END_BYTE) begin
              // Payload bytes from the third one on land in the store from channel 0.
              for (k = FIRST_DATA; k < length && k < MAX_PAYLOAD_DEF; k++) begin
                if (k - FIRST_DATA < NUM_CHANNELS_DEF) begin
                  levels[k - FIRST_DATA] = staging[k];
                  r.channels_written = r.channels_written + 1'b1;
                end
              end
              r.frame_done = 1'b1;
            end else begin
              r.frame_dropped = 1'b1;
            end
            phase = PH_HUNT;
          end
          default: phase = PH_HUNT;
        endcase
      end
      owed_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Compare one result against the oldest owed one.
    task check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result with no request waiting: %p", got));
      end else begin
        want = owed_results.pop_front();
        if (got.read_value !== want.read_value || got.frame_done !== want.frame_done ||
            got.frame_dropped !== want.frame_dropped ||
            got.channels_written !== want.channels_written)
          report_mismatch($sformatf("got %p, want %p", got, want));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  dmxfr_req_if req_if ();
  dmxfr_res_if res_if ();

  dmx_serial_frame_receiver_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dmx_frame_tracker tracker;
  int unsigned items_sent;
  int unsigned cycles;
  bit steady_window;

  always #5 clk_i = ~clk_i;

  // Cycle counter with a hard stop.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("dmx_serial_frame_receiver_top_tb: errors");
      $finish;
    end
  end

  // The result side stalls at random outside the steady window.
  always @(negedge clk_i) begin
    res_if.ready = steady_window || ($urandom_range(99) >= IDLE_PCT);
  end

  // Every accepted result is checked against the tracker.
  always @(posedge clk_i) begin : result_monitor
    result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.read_value = res_if.read_value;
      got.frame_done = res_if.frame_done;
      got.frame_dropped = res_if.frame_dropped;
      got.channels_written = res_if.channels_written;
      tracker.check_result(got);
    end
  end

  // Offer one request, with random idle cycles ahead of it, and wait for acceptance.
  task automatic send_request(input logic fn, input logic [BYTE_W-1:0] b,
                              input logic [CH_W-1:0] ch);
    @(negedge clk_i);
    while (!steady_window && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.func = fn;
    req_if.rx_byte = b;
    req_if.channel = ch;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    tracker.accept_request(fn, b, ch);
    items_sent++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    send_request(FUNC_BYTE, b, CH_W'($urandom_range(511)));
  endtask

  task automatic send_read(input logic [CH_W-1:0] ch);
    send_request(FUNC_READ, BYTE_W'($urandom_range(255)), ch);
  endtask

  // Start, optional repeated starts, label, length, and, if the length is in range, random payload and end byte.
  task automatic send_frame(input logic [15:0] len, input bit good_end,
                            input int unsigned extra_starts);
    int unsigned i;
    logic [BYTE_W-1:0] tail;
    send_byte(START_BYTE);
    for (i = 0; i < extra_starts; i++) send_byte(START_BYTE);
    send_byte(tracker.label);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (len <= MAX_PAYLOAD_DEF) begin
      for (i = 0; i < len; i++) send_byte(BYTE_W'($urandom_range(255)));
      tail = END_BYTE;
      while (!good_end && tail == END_BYTE) tail = BYTE_W'($urandom_range(255));
      send_byte(tail);
    end
  endtask

  // Stop offering requests and wait until every owed result has arrived.
  task automatic drain();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (tracker.owed_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.write_register(addr, data);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Read the label register back and compare it with the tracked value.
  task automatic apb_read_check();
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = LABEL_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {{(PDATA_W-BYTE_W){1'b0}}, tracker.label})
      tracker.report_mismatch($sformatf("label read %h, want %h", prdata, tracker.label));
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // One random piece of traffic: mostly good frames, some reads, noise and broken frames.
  task automatic random_action();
    int unsigned r;
    int unsigned n;
    int unsigned i;
    logic [15:0] len;
    logic [BYTE_W-1:0] b;
    r = $urandom_range(99);
    if (r < 6) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++)
        send_byte(($urandom_range(3) == 0) ? START_BYTE : BYTE_W'($urandom_range(255)));
    end else if (r < 16) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++)
        send_read(($urandom_range(1) == 0) ? CH_W'($urandom_range(31))
                                           : CH_W'($urandom_range(511)));
    end else if (r < 26) begin
      case ($urandom_range(2))
        0: begin
          // Start byte followed by something that is neither label nor start.
          send_byte(START_BYTE);
          b = BYTE_W'($urandom_range(255));
          while (b == tracker.label || b == START_BYTE) b = BYTE_W'($urandom_range(255));
          send_byte(b);
        end
        1: send_frame(16'($urandom_range(MAX_PAYLOAD_DEF + 1, 65535)), 1'b1, 0);
        default: send_frame(16'($urandom_range(24)), 1'b0, 0);
      endcase
    end else begin
      len = ($urandom_range(9) == 0) ? 16'($urandom_range(25, 80)) : 16'($urandom_range(24));
      n = (tracker.label != START_BYTE && $urandom_range(7) == 0) ? $urandom_range(1, 2) : 0;
      send_frame(len, 1'b1, n);
      if (len > 2 && $urandom_range(1) == 0) send_read(CH_W'($urandom_range(len - 3)));
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] phase_labels [5];
    logic [PDATA_W-1:0] data;
    int unsigned start;
    int unsigned p;
    tracker = new();
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.func = FUNC_BYTE;
    req_if.rx_byte = '0;
    req_if.channel = '0;
    res_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady_window = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed checks with the reset label.
    apb_read_check();
    apb_write(LABEL_ADDR, {24'hFFFFFF, LABEL_RESET});
    send_read(CH_W'(0));
    send_read(CH_W'(NUM_CHANNELS_DEF - 1));
    // Repeated start byte, then a three-byte payload with byte extremes.
    send_byte(START_BYTE);
    send_byte(START_BYTE);
    send_byte(tracker.label);
    send_byte(8'd3);
    send_byte(8'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(END_BYTE);
    send_read(CH_W'(0));
    // Length one above the limit is dropped on its high byte.
    send_byte(START_BYTE);
    send_byte(tracker.label);
    send_byte(8'h03);
    send_byte(8'h02);
    // Empty payload goes straight to the end byte.
    send_frame(16'd0, 1'b1, 0);
    // Bad end byte drops the frame.
    send_frame(16'd1, 1'b0, 0);
    // A stray byte after the start sends the parser back to hunting.
    send_byte(START_BYTE);
    send_byte(8'h33);

    // Random phases, each under its own label.
    phase_labels[0] = 8'h00;
    phase_labels[1] = 8'hFF;
    phase_labels[2] = START_BYTE;
    phase_labels[3] = BYTE_W'($urandom_range(255));
    phase_labels[4] = END_BYTE;
    for (p = 0; p < 5; p++) begin
      drain();
      data = $urandom;
      data[BYTE_W-1:0] = phase_labels[p];
      apb_write(LABEL_ADDR, data);
      if (p == 2) apb_write(UNUSED_ADDR, $urandom);
      apb_read_check();
      steady_window = (p == 3);
      if (p == 0) begin
        // One maximum-size frame fills the whole store.
        send_frame(16'(MAX_PAYLOAD_DEF), 1'b1, 0);
        send_read(CH_W'(NUM_CHANNELS_DEF - 1));
        send_read(CH_W'($urandom_range(511)));
      end
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) random_action();
      steady_window = 1'b0;
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (tracker.owed_results.size() != 0)
      tracker.report_mismatch($sformatf("%0d results never arrived",
                                        tracker.owed_results.size()));
    if (tracker.mismatches == 0) begin
      $display("dmx_serial_frame_receiver_top_tb: clean");
    end else begin
      $display("dmx_serial_frame_receiver_top_tb: errors");
    end
    $finish;
  end

endmodule
